// ===== hdl/tsa_pkg.sv =====
// Shared constants, codes and payload types for the tile slot allocator.
package tsa_pkg;

    localparam int TILE_SLOTS = 256;
    localparam int SLOT_W     = $clog2(TILE_SLOTS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int FRAME_W    = 32;
    localparam int MAP_W      = 32;
    localparam int OPC_W      = 3;

    localparam logic [CNT_W-1:0] SLOT_TOTAL = CNT_W'(TILE_SLOTS);

    // Operation codes
    localparam logic [OPC_W-1:0] OP_ALLOC = 3'd0;
    localparam logic [OPC_W-1:0] OP_FREE  = 3'd1;
    localparam logic [OPC_W-1:0] OP_EVICT = 3'd2;
    localparam logic [OPC_W-1:0] OP_TOUCH = 3'd3;
    localparam logic [OPC_W-1:0] OP_MAP   = 3'd4;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic [OPC_W-1:0]   opcode;
        logic [SLOT_W-1:0]  slot_index;
        logic [FRAME_W-1:0] frame_number;
        logic [MAP_W-1:0]   mapping_word;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_result;
        t_status           status;
    } t_out_item;

    // One slot table entry
    typedef struct packed {
        logic               occ;
        logic [FRAME_W-1:0] frame;
    } t_tbl_entry;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        t_tbl_entry        wr_entry;
        logic              clr_en;
        logic [SLOT_W-1:0] clr_addr;
    } t_tbl_req;

    typedef struct packed {
        logic              pop_rd;
        logic              pop;
        logic              push;
        logic [SLOT_W-1:0] push_slot;
    } t_stk_req;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [SLOT_W-1:0] pop_slot;
    } t_stk_sts;

endpackage

// ===== hdl/tsa_slot_table.sv =====
// Slot table memory: occupied bit and last-used frame per slot, with per-entry valid bits.
module tsa_slot_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rebuild,
    input  tsa_pkg::t_tbl_req i_req,
    output tsa_pkg::t_tbl_entry o_entry
);
    import tsa_pkg::*;

    t_tbl_entry             r_mem [TILE_SLOTS];
    logic [TILE_SLOTS-1:0]  r_valid;
    t_tbl_entry             r_q;
    logic                   r_q_valid;

    // Store written entries; no reset on the array
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_entry;
        end
        if (i_req.rd_en) begin
            r_q <= r_mem[i_req.rd_addr];
        end
    end

    // Track which entries hold written data; an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_rebuild) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
        end else begin
            if (i_req.rd_en) begin
                r_q_valid <= r_valid[i_req.rd_addr];
            end
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.clr_en) begin
                r_valid[i_req.clr_addr] <= 1'b0;
            end
        end
    end

    assign o_entry = r_q_valid ? r_q : '0;

endmodule

// ===== hdl/tsa_free_stack.sv =====
// Free slot stack: index memory, depth counter and refill by per-entry valid bits.
module tsa_free_stack (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rebuild,
    input  logic [tsa_pkg::CNT_W-1:0] i_rebuild_count,
    input  logic [tsa_pkg::CNT_W-1:0] i_count,
    input  tsa_pkg::t_stk_req         i_req,
    output tsa_pkg::t_stk_sts         o_sts
);
    import tsa_pkg::*;

    logic [SLOT_W-1:0]     r_mem [TILE_SLOTS];
    logic [TILE_SLOTS-1:0] r_valid;
    logic [CNT_W-1:0]      r_depth;
    logic [SLOT_W-1:0]     r_q;
    logic                  r_q_valid;
    logic [SLOT_W-1:0]     r_rd_pos;
    logic [SLOT_W-1:0]     rd_pos;
    logic [SLOT_W-1:0]     refill_slot;
    logic [CNT_W-1:0]      refill_sum;
    logic                  full;

    assign full        = (r_depth == SLOT_TOTAL);
    assign rd_pos      = SLOT_W'(r_depth - CNT_W'(1));
    // An unwritten position p below the count holds count-1-p after a refill
    assign refill_sum  = i_count - CNT_W'(1) - {1'b0, r_rd_pos};
    assign refill_slot = refill_sum[SLOT_W-1:0];

    // Write pushed indices and read the top of stack
    always_ff @(posedge i_clk) begin
        if (i_req.push && !full) begin
            r_mem[r_depth[SLOT_W-1:0]] <= i_req.push_slot;
        end
        if (i_req.pop_rd) begin
            r_q      <= r_mem[rd_pos];
            r_rd_pos <= rd_pos;
        end
    end

    // Advance the depth and the written marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
            r_depth   <= SLOT_TOTAL;
        end else if (i_rebuild) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
            r_depth   <= i_rebuild_count;
        end else begin
            if (i_req.pop_rd) begin
                r_q_valid <= r_valid[rd_pos];
            end
            if (i_req.pop) begin
                r_depth <= r_depth - CNT_W'(1);
            end else if (i_req.push && !full) begin
                r_valid[r_depth[SLOT_W-1:0]] <= 1'b1;
                r_depth                      <= r_depth + CNT_W'(1);
            end
        end
    end

    assign o_sts.empty    = (r_depth == '0);
    assign o_sts.full     = full;
    assign o_sts.pop_slot = r_q_valid ? r_q : refill_slot;

endmodule

// ===== hdl/tsa_ctrl.sv =====
// Operation sequencer: decodes each item and drives read-modify-write on table and stack.
module tsa_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  tsa_pkg::t_in_item         i_in_item,
    output logic                      o_in_ready,
    input  logic [tsa_pkg::CNT_W-1:0] i_count,
    output tsa_pkg::t_tbl_req         o_tbl_req,
    input  tsa_pkg::t_tbl_entry       i_tbl_entry,
    output tsa_pkg::t_stk_req         o_stk_req,
    input  tsa_pkg::t_stk_sts         i_stk_sts,
    output logic                      o_done_valid,
    output tsa_pkg::t_out_item        o_done_item,
    input  logic                      i_done_ack
);
    import tsa_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EXEC  = 8'b0000_0010,
        S_POP   = 8'b0000_0100,
        S_ALLOC = 8'b0000_1000,
        S_TOUCH = 8'b0001_0000,
        S_SCAN  = 8'b0010_0000,
        S_EVEND = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    t_in_item           r_item;
    logic [SLOT_W-1:0]  r_result;
    t_status            r_status;
    logic [FRAME_W-1:0] r_best;
    logic               r_found;
    logic [CNT_W-1:0]   r_scan_addr;
    logic [SLOT_W-1:0]  r_cmp_idx;
    logic               in_range;
    logic               scan_more;
    logic               older;

    assign in_range  = ({1'b0, r_item.slot_index} < i_count);
    assign scan_more = (r_scan_addr < i_count);
    assign older     = i_tbl_entry.occ && (i_tbl_entry.frame < r_best);

    // Next state and memory requests
    always_comb begin
        n_state   = r_state;
        o_tbl_req = '0;
        o_stk_req = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_item.opcode)
                    OP_ALLOC: begin
                        if (!i_stk_sts.empty) begin
                            o_stk_req.pop_rd = 1'b1;
                            n_state          = S_POP;
                        end
                    end
                    OP_FREE: begin
                        if (in_range) begin
                            o_tbl_req.clr_en    = 1'b1;
                            o_tbl_req.clr_addr  = r_item.slot_index;
                            o_stk_req.push      = 1'b1;
                            o_stk_req.push_slot = r_item.slot_index;
                        end
                    end
                    OP_EVICT: begin
                        if (i_count != '0) begin
                            o_tbl_req.rd_en   = 1'b1;
                            o_tbl_req.rd_addr = '0;
                            n_state           = S_SCAN;
                        end
                    end
                    OP_TOUCH: begin
                        if (in_range) begin
                            o_tbl_req.rd_en   = 1'b1;
                            o_tbl_req.rd_addr = r_item.slot_index;
                            n_state           = S_TOUCH;
                        end
                    end
                    default: begin
                        // set mapping: the mapping word has no read path, only the range check
                    end
                endcase
            end
            S_POP: begin
                o_stk_req.pop     = 1'b1;
                o_tbl_req.rd_en   = 1'b1;
                o_tbl_req.rd_addr = i_stk_sts.pop_slot;
                n_state           = S_ALLOC;
            end
            S_ALLOC: begin
                o_tbl_req.wr_en          = 1'b1;
                o_tbl_req.wr_addr        = r_result;
                o_tbl_req.wr_entry.occ   = 1'b1;
                o_tbl_req.wr_entry.frame = i_tbl_entry.frame;
                n_state                  = S_DONE;
            end
            S_TOUCH: begin
                o_tbl_req.wr_en          = 1'b1;
                o_tbl_req.wr_addr        = r_item.slot_index;
                o_tbl_req.wr_entry.occ   = i_tbl_entry.occ;
                o_tbl_req.wr_entry.frame = r_item.frame_number;
                n_state                  = S_DONE;
            end
            S_SCAN: begin
                if (scan_more) begin
                    o_tbl_req.rd_en   = 1'b1;
                    o_tbl_req.rd_addr = r_scan_addr[SLOT_W-1:0];
                end else begin
                    n_state = S_EVEND;
                end
            end
            S_EVEND: begin
                if (r_found) begin
                    o_tbl_req.clr_en   = 1'b1;
                    o_tbl_req.clr_addr = r_result;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_done_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the item and build the result
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_item   <= i_in_item;
                r_result <= '0;
                r_status <= ST_OK;
            end
            S_EXEC: begin
                r_best      <= r_item.frame_number;
                r_found     <= 1'b0;
                r_scan_addr <= CNT_W'(1);
                r_cmp_idx   <= '0;
                unique case (r_item.opcode)
                    OP_ALLOC: begin
                        if (i_stk_sts.empty) begin
                            r_status <= ST_NONE;
                        end
                    end
                    OP_FREE: begin
                        if (!in_range) begin
                            r_status <= ST_RANGE;
                        end else if (i_stk_sts.full) begin
                            r_status <= ST_FULL;
                        end
                    end
                    OP_EVICT: begin
                        if (i_count == '0) begin
                            r_status <= ST_NONE;
                        end
                    end
                    OP_TOUCH, OP_MAP: begin
                        if (!in_range) begin
                            r_status <= ST_RANGE;
                        end
                    end
                    default: begin
                        r_status <= ST_OK;
                    end
                endcase
            end
            S_POP: begin
                r_result <= i_stk_sts.pop_slot;
            end
            S_SCAN: begin
                // compare the entry read last cycle; strict less keeps the lower index on a tie
                if (older) begin
                    r_best   <= i_tbl_entry.frame;
                    r_result <= r_cmp_idx;
                    r_found  <= 1'b1;
                end
                r_cmp_idx   <= r_scan_addr[SLOT_W-1:0];
                r_scan_addr <= r_scan_addr + CNT_W'(1);
            end
            S_EVEND: begin
                if (!r_found) begin
                    r_status <= ST_NONE;
                    r_result <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready               = (r_state == S_IDLE);
    assign o_done_valid             = (r_state == S_DONE);
    assign o_done_item.slot_result  = r_result;
    assign o_done_item.status       = r_status;

endmodule

// ===== hdl/tile_slot_allocator_lru.sv =====
// Top level: slot count register, output register and the table, stack and sequencer.
// Input transfer to result valid: free, set mapping, unused codes, an empty-stack allocate,
// an out-of-range touch and an evict with no slots in use go EXEC then DONE; touch adds TOUCH,
// allocate adds POP and ALLOC, evict adds SCAN (one table read per slot, one port) and EVEND.
// The next item is taken the cycle after a result moves to the output register.
// Reset (synchronous, active low) sets tile_count to 256, all slots free, stack 255 down to 0.
module tile_slot_allocator_lru (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  tsa_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output tsa_pkg::t_out_item        o_out_item,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [tsa_pkg::CNT_W-1:0] i_cfg_data
);
    import tsa_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             rebuild;
    t_tbl_req         tbl_req;
    t_tbl_entry       tbl_entry;
    t_stk_req         stk_req;
    t_stk_sts         stk_sts;
    logic             done_valid;
    t_out_item        done_item;
    logic             done_ack;
    logic             r_out_valid;
    t_out_item        r_out_item;

    // Saturate the slot count to the table size
    assign o_cfg_ready = 1'b1;
    assign rebuild     = i_cfg_valid && o_cfg_ready;
    assign n_count     = (i_cfg_data > SLOT_TOTAL) ? SLOT_TOTAL : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= SLOT_TOTAL;
        end else if (rebuild) begin
            r_count <= n_count;
        end
    end

    tsa_slot_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rebuild (rebuild),
        .i_req     (tbl_req),
        .o_entry   (tbl_entry)
    );

    tsa_free_stack u_stack (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rebuild       (rebuild),
        .i_rebuild_count (n_count),
        .i_count         (r_count),
        .i_req           (stk_req),
        .o_sts           (stk_sts)
    );

    tsa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .o_in_ready   (o_in_ready),
        .i_count      (r_count),
        .o_tbl_req    (tbl_req),
        .i_tbl_entry  (tbl_entry),
        .o_stk_req    (stk_req),
        .i_stk_sts    (stk_sts),
        .o_done_valid (done_valid),
        .o_done_item  (done_item),
        .i_done_ack   (done_ack)
    );

    // Load the output register when it is empty or being drained
    assign done_ack = done_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_ack) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_ack) begin
            r_out_item <= done_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
